/* rtl/core/tdc_pkg.sv */
`default_nettype none

package tdc_pkg;

    localparam int TDC_QUEUE_DEPTH = 2;
    localparam int CFG_ADDR_W      = 4;
    localparam int CFG_DATA_W      = 32;
    localparam int WIN_W           = 17;

    localparam logic [4:0] MAX_HOUR      = 5'd23;
    localparam logic [4:0] HOURS_PER_DAY = 5'd24;
    localparam logic [5:0] MAX_MIN       = 6'd59;
    localparam logic [5:0] MIN_PER_HOUR  = 6'd60;

    localparam logic [WIN_W-1:0] SEC_PER_HOUR = 17'd3600;
    localparam logic [WIN_W-1:0] SEC_PER_MIN  = 17'd60;

    localparam logic [WIN_W-1:0] RST_WIN_A_LOW   = 17'd64800;
    localparam logic [WIN_W-1:0] RST_WIN_A_HIGH  = 17'd72000;
    localparam logic [WIN_W-1:0] RST_WIN_B_START = 17'd79200;
    localparam logic [WIN_W-1:0] RST_WIN_B_END   = 17'd14400;

    localparam logic [1:0] REG_WIN_A_LOW   = 2'd0;
    localparam logic [1:0] REG_WIN_A_HIGH  = 2'd1;
    localparam logic [1:0] REG_WIN_B_START = 2'd2;
    localparam logic [1:0] REG_WIN_B_END   = 2'd3;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_SET   = 2'd1,
        REQ_QUERY = 2'd2
    } t_req;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_hms;

    typedef struct packed {
        t_hms cur;
        t_hms other;
        logic sel;
    } t_job;

    typedef struct packed {
        logic [WIN_W-1:0] a_low;
        logic [WIN_W-1:0] a_high;
        logic [WIN_W-1:0] b_start;
        logic [WIN_W-1:0] b_end;
    } t_windows;

    typedef struct packed {
        t_hms cur;
        logic compare_true;
        t_hms diff;
        t_hms left;
        logic in_window_a;
        logic in_window_b;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/time_of_day_clock_compare_top.sv */
// Time-of-day counter with compare and window flags. Each request ticks the
// clock one second, sets the fields that are in range, or only queries; every
// request returns one result with the time after the step, a strict later or
// earlier flag, the absolute difference and the time left to midnight as h:m:s,
// and two window flags against the four APB window registers (byte addresses
// 0, 4, 8, 12). One request is taken every cycle while the queue is not full,
// with the time updated combinationally in the front end; a result passes
// through the queue and the output register, and a two-entry queue plus the
// output register absorb result-side stalls before the input side stops.
`default_nettype none

module time_of_day_clock_compare_top #(
    parameter int QUEUE_DEPTH = tdc_pkg::TDC_QUEUE_DEPTH
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire  [1:0]                       i_req_type,
    input  wire  [4:0]                       i_hour_in,
    input  wire  [5:0]                       i_minute_in,
    input  wire  [5:0]                       i_second_in,
    input  wire                              i_compare_sel,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [4:0]                       o_cur_hour,
    output logic [5:0]                       o_cur_minute,
    output logic [5:0]                       o_cur_second,
    output logic                             o_compare_true,
    output logic [4:0]                       o_diff_hour,
    output logic [5:0]                       o_diff_minute,
    output logic [5:0]                       o_diff_second,
    output logic [4:0]                       o_left_hour,
    output logic [5:0]                       o_left_minute,
    output logic [5:0]                       o_left_second,
    output logic                             o_in_window_a,
    output logic                             o_in_window_b,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [tdc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire  [tdc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [tdc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import tdc_pkg::*;

    t_windows r_win;
    t_job     w_push_job, w_q_job;
    t_result  w_result;
    logic     w_push, w_q_full, w_q_valid, w_pop;
    logic     w_cfg_wr;
    logic [1:0] w_reg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.a_low   <= RST_WIN_A_LOW;
            r_win.a_high  <= RST_WIN_A_HIGH;
            r_win.b_start <= RST_WIN_B_START;
            r_win.b_end   <= RST_WIN_B_END;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_WIN_A_LOW:   r_win.a_low   <= pwdata[WIN_W-1:0];
                REG_WIN_A_HIGH:  r_win.a_high  <= pwdata[WIN_W-1:0];
                REG_WIN_B_START: r_win.b_start <= pwdata[WIN_W-1:0];
                REG_WIN_B_END:   r_win.b_end   <= pwdata[WIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_WIN_A_LOW:   prdata = CFG_DATA_W'(r_win.a_low);
            REG_WIN_A_HIGH:  prdata = CFG_DATA_W'(r_win.a_high);
            REG_WIN_B_START: prdata = CFG_DATA_W'(r_win.b_start);
            REG_WIN_B_END:   prdata = CFG_DATA_W'(r_win.b_end);
            default:         prdata = '0;
        endcase
    end

    tdc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_hour_in     (i_hour_in),
        .i_minute_in   (i_minute_in),
        .i_second_in   (i_second_in),
        .i_compare_sel (i_compare_sel),
        .i_q_full      (w_q_full),
        .o_push        (w_push),
        .o_job         (w_push_job)
    );

    tdc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_job   (w_q_job)
    );

    tdc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_job       (w_q_job),
        .o_pop       (w_pop),
        .i_win       (r_win),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (w_result)
    );

    assign o_cur_hour     = w_result.cur.hour;
    assign o_cur_minute   = w_result.cur.minute;
    assign o_cur_second   = w_result.cur.second;
    assign o_compare_true = w_result.compare_true;
    assign o_diff_hour    = w_result.diff.hour;
    assign o_diff_minute  = w_result.diff.minute;
    assign o_diff_second  = w_result.diff.second;
    assign o_left_hour    = w_result.left.hour;
    assign o_left_minute  = w_result.left.minute;
    assign o_left_second  = w_result.left.second;
    assign o_in_window_a  = w_result.in_window_a;
    assign o_in_window_b  = w_result.in_window_b;

endmodule

`default_nettype wire

/* rtl/core/tdc_front.sv */
`default_nettype none

module tdc_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire  [1:0]        i_req_type,
    input  wire  [4:0]        i_hour_in,
    input  wire  [5:0]        i_minute_in,
    input  wire  [5:0]        i_second_in,
    input  wire               i_compare_sel,
    input  wire               i_q_full,
    output logic              o_push,
    output tdc_pkg::t_job     o_job
);
    import tdc_pkg::*;

    logic [4:0] r_hour, n_hour;
    logic [5:0] r_minute, n_minute;
    logic [5:0] r_second, n_second;
    logic       w_push;

    always_comb begin
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        unique case (t_req'(i_req_type))
            REQ_TICK: begin
                if (r_second == MAX_MIN) begin
                    n_second = '0;
                    if (r_minute == MAX_MIN) begin
                        n_minute = '0;
                        n_hour   = (r_hour == MAX_HOUR) ? '0 : r_hour + 5'd1;
                    end else begin
                        n_minute = r_minute + 6'd1;
                    end
                end else begin
                    n_second = r_second + 6'd1;
                end
            end
            REQ_SET: begin
                if (i_hour_in <= MAX_HOUR) n_hour = i_hour_in;
                if (i_minute_in <= MAX_MIN) n_minute = i_minute_in;
                if (i_second_in <= MAX_MIN) n_second = i_second_in;
            end
            default: begin
            end
        endcase
    end

    assign w_push     = i_in_valid && !i_q_full;
    assign o_push     = w_push;
    assign o_in_ready = !i_q_full;

    always_comb begin
        o_job.cur.hour     = n_hour;
        o_job.cur.minute   = n_minute;
        o_job.cur.second   = n_second;
        o_job.other.hour   = (i_hour_in <= MAX_HOUR) ? i_hour_in : '0;
        o_job.other.minute = (i_minute_in <= MAX_MIN) ? i_minute_in : '0;
        o_job.other.second = (i_second_in <= MAX_MIN) ? i_second_in : '0;
        o_job.sel          = i_compare_sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
        end else if (w_push) begin
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/tdc_queue.sv */
`default_nettype none

module tdc_queue #(
    parameter int DEPTH = tdc_pkg::TDC_QUEUE_DEPTH
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  tdc_pkg::t_job     i_job,
    output logic              o_full,
    input  wire               i_pop,
    output logic              o_valid,
    output tdc_pkg::t_job     o_job
);
    import tdc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];

    assign n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
    assign n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= n_wptr;
            if (i_pop) r_rptr <= n_rptr;
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/tdc_back.sv */
`default_nettype none

module tdc_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_valid,
    input  tdc_pkg::t_job       i_job,
    output logic                o_pop,
    input  tdc_pkg::t_windows   i_win,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output tdc_pkg::t_result    o_result
);
    import tdc_pkg::*;

    // a minus b on h:m:s fields with borrow, a not below b
    function automatic t_hms sub_hms(input t_hms a, input t_hms b);
        t_hms       r;
        logic [6:0] s_raw;
        logic [6:0] m_raw;
        s_raw    = {1'b0, a.second} - {1'b0, b.second};
        r.second = s_raw[6] ? s_raw[5:0] + MIN_PER_HOUR : s_raw[5:0];
        m_raw    = {1'b0, a.minute} - {1'b0, b.minute} - {6'd0, s_raw[6]};
        r.minute = m_raw[6] ? m_raw[5:0] + MIN_PER_HOUR : m_raw[5:0];
        r.hour   = a.hour - b.hour - {4'd0, m_raw[6]};
        return r;
    endfunction

    function automatic logic [WIN_W-1:0] to_sec(input t_hms t);
        return WIN_W'(t.hour) * SEC_PER_HOUR + WIN_W'(t.minute) * SEC_PER_MIN
             + WIN_W'(t.second);
    endfunction

    t_result          r_result, n_result;
    logic             r_valid;
    logic             w_pop;
    logic             w_gt, w_lt, w_zero;
    logic [WIN_W-1:0] w_cur_sec;
    t_hms             w_midnight;

    assign w_pop       = i_q_valid && (!r_valid || i_out_ready);
    assign o_pop       = w_pop;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_comb begin
        w_midnight.hour   = HOURS_PER_DAY;
        w_midnight.minute = '0;
        w_midnight.second = '0;
        w_gt      = (i_job.cur > i_job.other);
        w_lt      = (i_job.cur < i_job.other);
        w_zero    = (i_job.cur == '0);
        w_cur_sec = to_sec(i_job.cur);

        n_result.cur          = i_job.cur;
        n_result.compare_true = i_job.sel ? w_lt : w_gt;
        n_result.diff         = w_lt ? sub_hms(i_job.other, i_job.cur)
                                     : sub_hms(i_job.cur, i_job.other);
        n_result.left         = w_zero ? '0 : sub_hms(w_midnight, i_job.cur);
        n_result.in_window_a  = (w_cur_sec >= i_win.a_low) && (w_cur_sec <= i_win.a_high);
        n_result.in_window_b  = (w_cur_sec >= i_win.b_start) || (w_cur_sec < i_win.b_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_result <= n_result;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/tdc_checker.sv */
`default_nettype none

module tdc_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       o_out_valid,
    input wire       i_out_ready,
    input wire [4:0] o_cur_hour,
    input wire [5:0] o_cur_minute,
    input wire [5:0] o_cur_second,
    input wire [4:0] o_diff_hour,
    input wire [5:0] o_diff_minute,
    input wire [5:0] o_diff_second,
    input wire [4:0] o_left_hour,
    input wire [5:0] o_left_minute,
    input wire [5:0] o_left_second
);

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_cur_hour)
            && $stable(o_cur_minute) && $stable(o_cur_second))
        else $error("stalled result dropped or changed");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_cur_hour <= 5'd23 && o_cur_minute <= 6'd59
            && o_cur_second <= 6'd59 && o_diff_hour <= 5'd23
            && o_diff_minute <= 6'd59 && o_diff_second <= 6'd59)
        else $error("time or difference out of range");

    a_left_midnight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_cur_hour == 5'd0 && o_cur_minute == 6'd0
            && o_cur_second == 6'd0
        |-> o_left_hour == 5'd0 && o_left_minute == 6'd0 && o_left_second == 6'd0)
        else $error("time left not zero at midnight");

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_left_hour <= 5'd23 && o_left_minute <= 6'd59
            && o_left_second <= 6'd59)
        else $error("time left out of range");

endmodule

bind time_of_day_clock_compare_top tdc_checker u_tdc_checker (.*);

`default_nettype wire

/* tb/tb_time_of_day_clock_compare_top.sv */
`timescale 1ns / 100ps

module tb_time_of_day_clock_compare_top;

    import tdc_pkg::*;

    localparam int unsigned DAY_SECONDS    = 86400;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned WATCHDOG_LIMIT = 3000;

    // code left free by the package, behaves as a query
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       compare_sel;
    } t_tod_req;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_req_type    = '0;
    logic [4:0]  i_hour_in     = '0;
    logic [5:0]  i_minute_in   = '0;
    logic [5:0]  i_second_in   = '0;
    logic        i_compare_sel = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready   = 1'b0;
    logic [4:0]  o_cur_hour;
    logic [5:0]  o_cur_minute;
    logic [5:0]  o_cur_second;
    logic        o_compare_true;
    logic [4:0]  o_diff_hour;
    logic [5:0]  o_diff_minute;
    logic [5:0]  o_diff_second;
    logic [4:0]  o_left_hour;
    logic [5:0]  o_left_minute;
    logic [5:0]  o_left_second;
    logic        o_in_window_a;
    logic        o_in_window_b;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr  = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic        pready;

    time_of_day_clock_compare_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_hour_in      (i_hour_in),
        .i_minute_in    (i_minute_in),
        .i_second_in    (i_second_in),
        .i_compare_sel  (i_compare_sel),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_cur_hour     (o_cur_hour),
        .o_cur_minute   (o_cur_minute),
        .o_cur_second   (o_cur_second),
        .o_compare_true (o_compare_true),
        .o_diff_hour    (o_diff_hour),
        .o_diff_minute  (o_diff_minute),
        .o_diff_second  (o_diff_second),
        .o_left_hour    (o_left_hour),
        .o_left_minute  (o_left_minute),
        .o_left_second  (o_left_second),
        .o_in_window_a  (o_in_window_a),
        .o_in_window_b  (o_in_window_b),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_tod_req        pending_reqs[$];
    t_result         expected_times[$];
    t_tod_req        active_req;

    logic [4:0]      clk_hour   = '0;
    logic [5:0]      clk_minute = '0;
    logic [5:0]      clk_second = '0;
    logic [WIN_W-1:0] win_a_low   = RST_WIN_A_LOW;
    logic [WIN_W-1:0] win_a_high  = RST_WIN_A_HIGH;
    logic [WIN_W-1:0] win_b_start = RST_WIN_B_START;
    logic [WIN_W-1:0] win_b_end   = RST_WIN_B_END;

    int unsigned error_count   = 0;
    int unsigned send_idle_max = 0;
    int unsigned recv_idle_max = 0;
    int unsigned send_wait     = 0;
    int unsigned recv_wait     = 0;
    int unsigned hold_gen      = 0;
    int unsigned hold_taken    = 0;
    int unsigned hold_left     = 0;
    int unsigned idle_cycles   = 0;

    function automatic t_hms split_seconds(input int unsigned total);
        t_hms parts;
        parts.hour   = 5'(total / SEC_PER_HOUR);
        parts.minute = 6'((total % SEC_PER_HOUR) / SEC_PER_MIN);
        parts.second = 6'(total % SEC_PER_MIN);
        return parts;
    endfunction

    function automatic t_result advance_time_of_day(input t_tod_req rq);
        t_result     res;
        int unsigned now_s;
        int unsigned in_s;
        int unsigned hh;
        int unsigned mm;
        int unsigned ss;
        int unsigned gap_s;
        hh = rq.hour;
        mm = rq.minute;
        ss = rq.second;
        if (rq.req_type == REQ_TICK) begin
            now_s = clk_hour * SEC_PER_HOUR + clk_minute * SEC_PER_MIN + clk_second + 1;
            if (now_s >= DAY_SECONDS) now_s = 0;
            clk_hour   = 5'(now_s / SEC_PER_HOUR);
            clk_minute = 6'((now_s % SEC_PER_HOUR) / SEC_PER_MIN);
            clk_second = 6'(now_s % SEC_PER_MIN);
        end else if (rq.req_type == REQ_SET) begin
            if (hh <= MAX_HOUR) clk_hour = rq.hour;
            if (mm <= MAX_MIN) clk_minute = rq.minute;
            if (ss <= MAX_MIN) clk_second = rq.second;
        end
        now_s = clk_hour * SEC_PER_HOUR + clk_minute * SEC_PER_MIN + clk_second;
        if (hh > MAX_HOUR) hh = 0;
        if (mm > MAX_MIN) mm = 0;
        if (ss > MAX_MIN) ss = 0;
        in_s  = hh * SEC_PER_HOUR + mm * SEC_PER_MIN + ss;
        gap_s = (now_s >= in_s) ? now_s - in_s : in_s - now_s;
        res.cur.hour     = clk_hour;
        res.cur.minute   = clk_minute;
        res.cur.second   = clk_second;
        res.compare_true = rq.compare_sel ? (now_s < in_s) : (now_s > in_s);
        res.diff         = split_seconds(gap_s);
        res.left         = split_seconds((now_s == 0) ? 0 : DAY_SECONDS - now_s);
        res.in_window_a  = (now_s >= win_a_low) && (now_s <= win_a_high);
        res.in_window_b  = (now_s >= win_b_start) || (now_s < win_b_end);
        return res;
    endfunction

    task automatic check_field(input string label, input int unsigned want_v,
                               input int unsigned seen_v);
        if (want_v != seen_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, label, want_v, seen_v);
            error_count++;
        end
    endtask

    // request driver
    always @(posedge i_clk) begin : request_driver
        logic load_next;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            load_next = !i_in_valid;
            if (i_in_valid && o_in_ready) begin
                expected_times.push_back(advance_time_of_day(active_req));
                load_next = 1'b1;
                send_wait = $urandom_range(0, send_idle_max);
            end
            if (load_next) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    active_req = pending_reqs.pop_front();
                    i_in_valid    <= 1'b1;
                    i_req_type    <= active_req.req_type;
                    i_hour_in     <= active_req.hour;
                    i_minute_in   <= active_req.minute;
                    i_second_in   <= active_req.second;
                    i_compare_sel <= active_req.compare_sel;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : result_monitor
        t_result seen;
        t_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                seen.cur.hour     = o_cur_hour;
                seen.cur.minute   = o_cur_minute;
                seen.cur.second   = o_cur_second;
                seen.compare_true = o_compare_true;
                seen.diff.hour    = o_diff_hour;
                seen.diff.minute  = o_diff_minute;
                seen.diff.second  = o_diff_second;
                seen.left.hour    = o_left_hour;
                seen.left.minute  = o_left_minute;
                seen.left.second  = o_left_second;
                seen.in_window_a  = o_in_window_a;
                seen.in_window_b  = o_in_window_b;
                if (expected_times.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d:%0d:%0d",
                             $time, seen.cur.hour, seen.cur.minute, seen.cur.second);
                    error_count++;
                end else begin
                    want = expected_times.pop_front();
                    check_field("cur_hour", want.cur.hour, seen.cur.hour);
                    check_field("cur_minute", want.cur.minute, seen.cur.minute);
                    check_field("cur_second", want.cur.second, seen.cur.second);
                    check_field("compare_true", want.compare_true, seen.compare_true);
                    check_field("diff_hour", want.diff.hour, seen.diff.hour);
                    check_field("diff_minute", want.diff.minute, seen.diff.minute);
                    check_field("diff_second", want.diff.second, seen.diff.second);
                    check_field("left_hour", want.left.hour, seen.left.hour);
                    check_field("left_minute", want.left.minute, seen.left.minute);
                    check_field("left_second", want.left.second, seen.left.second);
                    check_field("in_window_a", want.in_window_a, seen.in_window_a);
                    check_field("in_window_b", want.in_window_b, seen.in_window_b);
                end
                recv_wait = $urandom_range(0, recv_idle_max);
            end
            if (hold_taken != hold_gen) begin
                hold_taken = hold_gen;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("time_of_day_clock_compare_top test failed");
                $finish;
            end
        end
    end

    task automatic apb_write(input logic [1:0] index, input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_WIN_A_LOW: begin
                win_a_low = value[WIN_W-1:0];
            end
            REG_WIN_A_HIGH: begin
                win_a_high = value[WIN_W-1:0];
            end
            REG_WIN_B_START: begin
                win_b_start = value[WIN_W-1:0];
            end
            default: begin
                win_b_end = value[WIN_W-1:0];
            end
        endcase
    endtask

    task automatic write_windows(input logic [CFG_DATA_W-1:0] a_low,
                                 input logic [CFG_DATA_W-1:0] a_high,
                                 input logic [CFG_DATA_W-1:0] b_start,
                                 input logic [CFG_DATA_W-1:0] b_end);
        apb_write(REG_WIN_A_LOW, a_low);
        apb_write(REG_WIN_A_HIGH, a_high);
        apb_write(REG_WIN_B_START, b_start);
        apb_write(REG_WIN_B_END, b_end);
    endtask

    task automatic queue_request(input logic [1:0] kind, input int unsigned hh,
                                 input int unsigned mm, input int unsigned ss,
                                 input int unsigned sel);
        t_tod_req rq;
        rq.req_type    = kind;
        rq.hour        = 5'(hh);
        rq.minute      = 6'(mm);
        rq.second      = 6'(ss);
        rq.compare_sel = 1'(sel);
        pending_reqs.push_back(rq);
    endtask

    function automatic int unsigned pick_field(input int unsigned limit,
                                               input int unsigned full_max);
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, full_max);
        return $urandom_range(0, limit);
    endfunction

    function automatic logic [1:0] pick_kind();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 4) return REQ_TICK;
        if (roll < 7) return REQ_SET;
        if (roll < 9) return REQ_QUERY;
        return REQ_UNUSED;
    endfunction

    // set just short of a window edge or midnight, then tick across it
    task automatic queue_edge_run(output int unsigned queued);
        int unsigned target;
        int unsigned start_s;
        case ($urandom_range(0, 4))
            0: target = win_a_low;
            1: target = win_a_high + 1;
            2: target = win_b_start;
            3: target = win_b_end;
            default: target = 0;
        endcase
        if (target >= DAY_SECONDS) target = 0;
        start_s = (target + DAY_SECONDS - 2) % DAY_SECONDS;
        queue_request(REQ_SET, start_s / SEC_PER_HOUR, (start_s % SEC_PER_HOUR) / SEC_PER_MIN,
                      start_s % SEC_PER_MIN, $urandom_range(0, 1));
        repeat (4) begin
            queue_request(REQ_TICK, pick_field(MAX_HOUR, 31), pick_field(MAX_MIN, 63),
                          pick_field(MAX_MIN, 63), $urandom_range(0, 1));
        end
        queued = 5;
    endtask

    task automatic drain_results();
        while (pending_reqs.size() != 0 || i_in_valid || expected_times.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random_phase(input int unsigned n_items, input int unsigned send_max,
                                    input int unsigned recv_max, input bit with_hold);
        int unsigned queued;
        int unsigned run_len;
        send_idle_max = send_max;
        recv_idle_max = recv_max;
        queued = 0;
        while (queued < n_items) begin
            if ($urandom_range(0, 11) == 0) begin
                queue_edge_run(run_len);
                queued += run_len;
            end else begin
                queue_request(pick_kind(), pick_field(MAX_HOUR, 31), pick_field(MAX_MIN, 63),
                              pick_field(MAX_MIN, 63), $urandom_range(0, 1));
                queued++;
            end
        end
        if (with_hold) hold_gen++;
        drain_results();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_max = 2;
        recv_idle_max = 2;
        queue_request(REQ_QUERY, 0, 0, 0, 1'b0);
        queue_request(REQ_QUERY, 0, 0, 0, 1'b1);
        queue_request(REQ_SET, 23, 59, 59, 1'b0);
        queue_request(REQ_TICK, 23, 59, 59, 1'b1);
        queue_request(REQ_QUERY, 31, 63, 63, 1'b0);
        queue_request(REQ_SET, 31, 63, 63, 1'b1);
        queue_request(REQ_SET, 12, 63, 30, 1'b0);
        queue_request(REQ_SET, 31, 45, 63, 1'b1);
        queue_request(REQ_UNUSED, 23, 59, 59, 1'b1);
        queue_request(REQ_TICK, 0, 0, 0, 1'b0);
        queue_request(REQ_SET, 0, 0, 0, 1'b0);
        queue_request(REQ_QUERY, 23, 59, 59, 1'b0);
        queue_request(REQ_QUERY, 23, 59, 59, 1'b1);
        queue_request(REQ_SET, 17, 59, 59, 1'b0);
        queue_request(REQ_TICK, 18, 0, 0, 1'b1);
        queue_request(REQ_SET, 20, 0, 0, 1'b0);
        queue_request(REQ_TICK, 20, 0, 0, 1'b0);
        queue_request(REQ_SET, 21, 59, 59, 1'b1);
        queue_request(REQ_TICK, 22, 0, 0, 1'b1);
        queue_request(REQ_SET, 3, 59, 59, 1'b0);
        queue_request(REQ_TICK, 4, 0, 0, 1'b0);
        queue_request(REQ_SET, 23, 59, 58, 1'b1);
        queue_request(REQ_TICK, 0, 0, 1, 1'b1);
        queue_request(REQ_TICK, 0, 0, 1, 1'b0);
        drain_results();

        run_random_phase(200, 4, 4, 1'b1);

        write_windows(0, DAY_SECONDS - 1, 0, 0);
        run_random_phase(150, 0, 0, 1'b0);

        write_windows(DAY_SECONDS - 1, 0, DAY_SECONDS - 1, DAY_SECONDS - 1);
        run_random_phase(150, 0, 4, 1'b0);

        // upper data bits set; all window values but A high lie beyond one day
        write_windows(32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF);
        run_random_phase(150, 4, 0, 1'b0);

        write_windows($urandom_range(0, 43200), $urandom_range(43200, DAY_SECONDS - 1),
                      $urandom_range(0, 43200), $urandom_range(43200, DAY_SECONDS - 1));
        run_random_phase(175, 3, 4, 1'b1);

        write_windows($urandom_range(0, DAY_SECONDS - 1), $urandom_range(0, DAY_SECONDS - 1),
                      $urandom_range(0, DAY_SECONDS - 1), $urandom_range(0, DAY_SECONDS - 1));
        run_random_phase(175, 4, 2, 1'b0);

        if (error_count == 0) begin
            $display("time_of_day_clock_compare_top test passed");
        end else begin
            $display("time_of_day_clock_compare_top test failed");
        end
        $finish;
    end

endmodule
